[rtl/swm_pkg.sv]
`default_nettype none
package swm_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int WINDOW_MAX   = 16;
	localparam int CFG_W        = 5;
	localparam int IDX_W        = $clog2(WINDOW_MAX);
	localparam int AGE_W        = $clog2(WINDOW_MAX);
	localparam int AINC_W       = AGE_W + 1;
	localparam int FILL_W       = $clog2(WINDOW_MAX + 1);
	localparam int MED_W        = SAMPLE_WIDTH + 1;

	localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(3);

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_AGE,
		OP_COMPACT,
		OP_INSERT
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AGE,
		S_COMPACT,
		S_INSERT,
		S_MEDIAN
	} state_t;

	typedef struct packed {
		logic                           valid;
		logic signed [SAMPLE_WIDTH-1:0] value;
		logic [AGE_W-1:0]               age;
	} cell_t;

	typedef struct packed {
		op_t                            op;
		logic                           restart;
		logic [FILL_W-1:0]              ws;
		logic signed [SAMPLE_WIDTH-1:0] sample;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/swm_in_if.sv]
`default_nettype none
interface swm_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample;
	logic                                    restart_window;
	logic                                    seq_end;

	modport source (output valid, output sample, output restart_window, output seq_end,
		input ready);
	modport sink (input valid, input sample, input restart_window, input seq_end,
		output ready);
endinterface
`default_nettype wire

[rtl/swm_out_if.sv]
`default_nettype none
interface swm_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [swm_pkg::MED_W-1:0] median_doubled;
	logic [swm_pkg::FILL_W-1:0]       window_fill;
	logic                             seq_end_out;

	modport source (output valid, output median_doubled, output window_fill,
		output seq_end_out, input ready);
	modport sink (input valid, input median_doubled, input window_fill,
		input seq_end_out, output ready);
endinterface
`default_nettype wire

[rtl/sliding_window_median_core.sv]
`default_nettype none
// Running median filter over the most recent samples of a stream.
// The input channel carries one signed sample per word, with a restart flag
// that empties the window before the sample and an end flag that is passed
// through. The output channel gives one word per input word: twice the median
// of the window (exact for even fills), the number of samples used, and the
// end flag. The window size register is written with cfg_we; it takes effect
// on the next sample and must be written while the block is idle.
// The window lives in a row of cells kept in ascending order. Each sample
// goes through these steps from acceptance to a valid output word: age the
// cells and drop those that leave the window; close up the holes left by
// samples dropped from inside the row (normally one once the window is full,
// more after the window size is lowered, none on a restart), one compaction
// step per hole plus a final check; insert the sample; select the median.
// One sample is in the row at a time; a new one is accepted once it is done.
// The output word sits in its own register, so the next sample is taken while
// a finished word waits for the receiver; a stalled receiver then holds the
// row at its median step. Reset empties the window and sets the size to 3.
module sliding_window_median_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	swm_in_if.sink                          in_ch,
	swm_out_if.source                       out_ch,
	input  wire logic                       cfg_we,
	input  wire logic [swm_pkg::CFG_W-1:0]  cfg_wdata
);

	swm_pkg::state_t                        state_q, state_d;
	logic [swm_pkg::CFG_W-1:0]              ws_q;
	logic [swm_pkg::FILL_W-1:0]             ws_eff;
	logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample_q;
	logic                                   restart_q;
	logic                                   seq_end_q;
	swm_pkg::cell_ctl_t                     ctl;
	swm_pkg::op_t                           op;

	swm_pkg::cell_t                         cells [swm_pkg::WINDOW_MAX];
	logic [swm_pkg::WINDOW_MAX:0]           take_c;
	logic [swm_pkg::WINDOW_MAX:0]           hole_c;
	logic [swm_pkg::WINDOW_MAX-1:0]         gaps;
	logic                                   any_gap;

	logic [swm_pkg::FILL_W-1:0]             fill;
	logic [swm_pkg::FILL_W-1:0]             fill_dec;
	logic [swm_pkg::FILL_W-1:0]             hi_pos;
	logic [swm_pkg::IDX_W-1:0]              lo_idx;
	logic [swm_pkg::IDX_W-1:0]              hi_idx;
	logic signed [swm_pkg::SAMPLE_WIDTH-1:0] lo_val;
	logic signed [swm_pkg::SAMPLE_WIDTH-1:0] hi_val;
	logic signed [swm_pkg::MED_W-1:0]       med2;

	logic                                   out_free;
	logic                                   load_out;
	logic                                   out_valid_q;
	logic signed [swm_pkg::MED_W-1:0]       med_q;
	logic [swm_pkg::FILL_W-1:0]             fill_q;
	logic                                   seq_end_out_q;

	always_comb begin
		if (ws_q == '0) begin
			ws_eff = swm_pkg::FILL_W'(1);
		end else if (32'(ws_q) > swm_pkg::WINDOW_MAX) begin
			ws_eff = swm_pkg::FILL_W'(swm_pkg::WINDOW_MAX);
		end else begin
			ws_eff = swm_pkg::FILL_W'(ws_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= swm_pkg::WS_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	assign in_ch.ready = (state_q == swm_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_q  <= in_ch.sample;
			restart_q <= in_ch.restart_window;
			seq_end_q <= in_ch.seq_end;
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = swm_pkg::OP_HOLD;
		load_out = 1'b0;
		case (state_q)
			swm_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					state_d = swm_pkg::S_AGE;
				end
			end
			swm_pkg::S_AGE: begin
				op      = swm_pkg::OP_AGE;
				state_d = swm_pkg::S_COMPACT;
			end
			swm_pkg::S_COMPACT: begin
				if (any_gap) begin
					op = swm_pkg::OP_COMPACT;
				end else begin
					state_d = swm_pkg::S_INSERT;
				end
			end
			swm_pkg::S_INSERT: begin
				op      = swm_pkg::OP_INSERT;
				state_d = swm_pkg::S_MEDIAN;
			end
			swm_pkg::S_MEDIAN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = swm_pkg::S_IDLE;
				end
			end
			default: state_d = swm_pkg::S_IDLE;
		endcase
	end

	assign ctl.op      = op;
	assign ctl.restart = restart_q;
	assign ctl.ws      = ws_eff;
	assign ctl.sample  = sample_q;

	assign take_c[0] = 1'b0;
	assign hole_c[0] = 1'b0;

	for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
		swm_pkg::cell_t left_n;
		swm_pkg::cell_t right_n;
		if (i == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = cells[i-1];
		end
		if (i == swm_pkg::WINDOW_MAX - 1) begin : g_last
			assign right_n = '0;
		end else begin : g_mid_r
			assign right_n = cells[i+1];
		end
		swm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left      (left_n),
			.left_take (take_c[i]),
			.right     (right_n),
			.hole_in   (hole_c[i]),
			.data      (cells[i]),
			.take      (take_c[i+1]),
			.hole_out  (hole_c[i+1]),
			.gap       (gaps[i])
		);
	end

	assign any_gap = |gaps;

	always_comb begin
		fill   = '0;
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
			fill = fill + swm_pkg::FILL_W'(cells[i].valid);
		end
		fill_dec = fill - swm_pkg::FILL_W'(1);
		hi_pos   = fill >> 1;
		lo_idx   = fill_dec[swm_pkg::FILL_W-1:1];
		hi_idx   = hi_pos[swm_pkg::IDX_W-1:0];
		for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
			if (swm_pkg::IDX_W'(i) == lo_idx) begin
				lo_val = cells[i].value;
			end
			if (swm_pkg::IDX_W'(i) == hi_idx) begin
				hi_val = cells[i].value;
			end
		end
		med2 = swm_pkg::MED_W'(lo_val) + swm_pkg::MED_W'(hi_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			med_q         <= med2;
			fill_q        <= fill;
			seq_end_out_q <= seq_end_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.median_doubled = med_q;
	assign out_ch.window_fill    = fill_q;
	assign out_ch.seq_end_out    = seq_end_out_q;

endmodule
`default_nettype wire

[rtl/swm_cell.sv]
`default_nettype none
module swm_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire swm_pkg::cell_ctl_t ctl,
	input  wire swm_pkg::cell_t     left,
	input  wire logic               left_take,
	input  wire swm_pkg::cell_t     right,
	input  wire logic               hole_in,
	output swm_pkg::cell_t          data,
	output logic                    take,
	output logic                    hole_out,
	output logic                    gap
);

	logic                                    valid_q;
	logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_q;
	logic [swm_pkg::AGE_W-1:0]               age_q;
	logic [swm_pkg::AINC_W-1:0]              age_inc;
	logic                                    keep;

	assign age_inc  = {1'b0, age_q} + swm_pkg::AINC_W'(1);
	assign keep     = valid_q && !ctl.restart && (age_inc < swm_pkg::AINC_W'(ctl.ws));
	assign take     = !valid_q || (value_q > ctl.sample);
	assign hole_out = hole_in || !valid_q;
	assign gap      = valid_q && hole_in;
	assign data     = {valid_q, value_q, age_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				swm_pkg::OP_AGE: valid_q <= keep;
				swm_pkg::OP_COMPACT: begin
					if (hole_out) begin
						valid_q <= right.valid;
					end
				end
				swm_pkg::OP_INSERT: begin
					if (take) begin
						valid_q <= left_take ? left.valid : 1'b1;
					end
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			swm_pkg::OP_AGE: age_q <= age_inc[swm_pkg::AGE_W-1:0];
			swm_pkg::OP_COMPACT: begin
				if (hole_out) begin
					value_q <= right.value;
					age_q   <= right.age;
				end
			end
			swm_pkg::OP_INSERT: begin
				if (take) begin
					value_q <= left_take ? left.value : ctl.sample;
					age_q   <= left_take ? left.age : '0;
				end
			end
			default: age_q <= age_q;
		endcase
	end

endmodule
`default_nettype wire

[rtl/swm_checker.sv]
`default_nettype none
module swm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [swm_pkg::MED_W-1:0] out_med,
	input wire logic [swm_pkg::FILL_W-1:0]       out_fill
);

	// A held output word keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_med))
		else $error("output word changed while stalled");

	// The row works on one sample at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in the row");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_fill != '0 && 32'(out_fill) <= swm_pkg::WINDOW_MAX)
		else $error("window fill out of range");

	// With an odd fill the result is twice one sample, hence even.
	a_odd_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_fill[0] |-> !out_med[0])
		else $error("odd fill gave an odd doubled median");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_med   (out_ch.median_doubled),
	.out_fill  (out_ch.window_fill)
);
`default_nettype wire
